>>> hw/rtl/btd_pkg.sv
package btd_pkg;

	// Default width of the string length counter
	localparam int BTD_LENGTH_WIDTH = 32;

	// Event codes of a result item
	localparam logic [2:0] EV_PENDING = 3'd0;
	localparam logic [2:0] EV_BYTE    = 3'd1;
	localparam logic [2:0] EV_INT     = 3'd2;
	localparam logic [2:0] EV_EMPTY   = 3'd3;
	localparam logic [2:0] EV_ERROR   = 3'd4;

	// Error codes of a result item
	localparam logic [2:0] ER_NONE  = 3'd0;
	localparam logic [2:0] ER_FIRST = 3'd1;
	localparam logic [2:0] ER_INT   = 3'd2;
	localparam logic [2:0] ER_OVF   = 3'd3;
	localparam logic [2:0] ER_LEN   = 3'd4;
	localparam logic [2:0] ER_TRUNC = 3'd5;

	// Token bytes
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Magnitude of the most negative 64-bit value, widened for the overflow check
	localparam logic [67:0] INT_NEG_LIMIT = 68'h0_8000_0000_0000_0000;

	// One result item
	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  str_byte;
		logic        str_last;
		logic [63:0] int_value;
		logic [2:0]  err_code;
	} btd_result_t;

endpackage

>>> hw/rtl/btd_decode.sv
module btd_decode
	import btd_pkg::*;
#(
	parameter int LENGTH_WIDTH = BTD_LENGTH_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  in_byte,
	input  logic        stream_end,
	output btd_result_t res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_INT_START,
		PH_INT_SIGN,
		PH_INT_DIGITS,
		PH_LEN,
		PH_STR
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [63:0]             mag_q, mag_d;
	logic                    neg_q, neg_d;
	logic                    dseen_q, dseen_d;
	logic                    lzero_q, lzero_d;
	logic [LENGTH_WIDTH-1:0] rem_q, rem_d;

	logic                    is_digit;
	logic [3:0]              digit;
	logic [67:0]             int_prod;
	logic                    int_ovf;
	logic [LENGTH_WIDTH+3:0] len_prod;
	logic                    len_ovf;

	// Classify the byte and form the times-ten products
	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign digit    = in_byte[3:0];
	assign int_prod = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {64'b0, digit};
	assign int_ovf  = (int_prod[67:63] != 5'b0) && !(neg_q && (int_prod == INT_NEG_LIMIT));
	assign len_prod = ({4'b0, rem_q} << 3) + ({4'b0, rem_q} << 1)
		+ {{LENGTH_WIDTH{1'b0}}, digit};
	assign len_ovf  = (len_prod[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'b0);

	// Next state and result for one byte
	always_comb begin
		phase_d = phase_q;
		mag_d   = mag_q;
		neg_d   = neg_q;
		dseen_d = dseen_q;
		lzero_d = lzero_q;
		rem_d   = rem_q;
		res     = '0;

		if (stream_end) begin
			if (phase_q != PH_IDLE) begin
				phase_d = PH_IDLE;
				mag_d = '0; neg_d = 1'b0; dseen_d = 1'b0; lzero_d = 1'b0; rem_d = '0;
				res.event_res = EV_ERROR;
				res.err_code  = ER_TRUNC;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					mag_d = '0; neg_d = 1'b0; dseen_d = 1'b0; lzero_d = 1'b0; rem_d = '0;
					if (in_byte == CH_I) begin
						phase_d = PH_INT_START;
					end else if (is_digit) begin
						rem_d   = {{(LENGTH_WIDTH-4){1'b0}}, digit};
						phase_d = PH_LEN;
					end else begin
						res.event_res = EV_ERROR;
						res.err_code  = ER_FIRST;
					end
				end
				PH_INT_START, PH_INT_SIGN, PH_INT_DIGITS: begin
					if (phase_q == PH_INT_START && (in_byte == CH_MINUS || in_byte == CH_PLUS))
					begin
						neg_d   = (in_byte == CH_MINUS);
						phase_d = PH_INT_SIGN;
					end else if (is_digit && !lzero_q && !int_ovf) begin
						if (!dseen_q && digit == 4'd0) begin
							lzero_d = 1'b1;
						end
						mag_d   = int_prod[63:0];
						dseen_d = 1'b1;
						phase_d = PH_INT_DIGITS;
					end else if (in_byte == CH_E && dseen_q) begin
						phase_d = PH_IDLE;
						mag_d = '0; neg_d = 1'b0; dseen_d = 1'b0; lzero_d = 1'b0; rem_d = '0;
						res.event_res = EV_INT;
						res.int_value = neg_q ? (64'd0 - mag_q) : mag_q;
					end else begin
						// leading zero wins over overflow
						phase_d = PH_IDLE;
						mag_d = '0; neg_d = 1'b0; dseen_d = 1'b0; lzero_d = 1'b0; rem_d = '0;
						res.event_res = EV_ERROR;
						res.err_code  = (is_digit && !lzero_q) ? ER_OVF : ER_INT;
					end
				end
				PH_LEN: begin
					if (is_digit && !len_ovf) begin
						rem_d = len_prod[LENGTH_WIDTH-1:0];
					end else if (in_byte == CH_COLON) begin
						if (rem_q == '0) begin
							phase_d = PH_IDLE;
							mag_d = '0; neg_d = 1'b0; dseen_d = 1'b0; lzero_d = 1'b0;
							rem_d = '0;
							res.event_res = EV_EMPTY;
						end else begin
							phase_d = PH_STR;
						end
					end else begin
						phase_d = PH_IDLE;
						mag_d = '0; neg_d = 1'b0; dseen_d = 1'b0; lzero_d = 1'b0; rem_d = '0;
						res.event_res = EV_ERROR;
						res.err_code  = ER_LEN;
					end
				end
				PH_STR: begin
					res.event_res = EV_BYTE;
					res.str_byte  = in_byte;
					if (rem_q[LENGTH_WIDTH-1:1] == '0) begin
						res.str_last = 1'b1;
						phase_d = PH_IDLE;
						mag_d = '0; neg_d = 1'b0; dseen_d = 1'b0; lzero_d = 1'b0; rem_d = '0;
					end else begin
						rem_d = rem_q - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
					end
				end
				default: begin
					phase_d = PH_IDLE;
					mag_d = '0; neg_d = 1'b0; dseen_d = 1'b0; lzero_d = 1'b0; rem_d = '0;
				end
			endcase
		end
	end

	// Hold token state, advance on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			dseen_q <= 1'b0;
			lzero_q <= 1'b0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			mag_q   <= mag_d;
			neg_q   <= neg_d;
			dseen_q <= dseen_d;
			lzero_q <= lzero_d;
			rem_q   <= rem_d;
		end
	end

	// String phase always has bytes left to take
	a_str_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STR) |-> (rem_q != '0))
		else $error("string phase with zero remaining count");

	// Idle carries no leftover token state
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (mag_q == '0 && !neg_q && !dseen_q && !lzero_q && rem_q == '0))
		else $error("token state not cleared in idle");

	// Digit flag tracks the digits phase
	a_digits_phase: assert property (@(posedge clk) disable iff (!arst_n)
		dseen_q == (phase_q == PH_INT_DIGITS))
		else $error("digit flag out of step with phase");

	// Leading zero only ever stands alone
	a_lzero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		lzero_q |-> (mag_q == '0 && phase_q == PH_INT_DIGITS))
		else $error("leading zero with nonzero magnitude");

endmodule

>>> hw/rtl/bencode_token_decoder.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  in_byte, stream_end
// out      output     out_valid/out_ready  event_res, str_byte, str_last, int_value, err_code
//
// One result per input byte; one byte accepted every cycle while the result is not stalled;
// each byte passes through the input register and then the result register.
// The token state updates as a byte moves from the input register to the result register.
// arst_n clears token state and both valid flags; the decoder starts in idle.
// A stalled result holds the pipeline; an empty input register still takes a byte while it waits.
module bencode_token_decoder
	import btd_pkg::*;
#(
	parameter int LENGTH_WIDTH = BTD_LENGTH_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [7:0]  str_byte,
	output logic        str_last,
	output logic [63:0] int_value,
	output logic [2:0]  err_code
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        valid_s2;
	btd_result_t res_s2;
	btd_result_t res;
	logic        advance;
	logic        step;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	btd_decode #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_byte   (byte_s1),
		.stream_end(end_s1),
		.res       (res)
	);

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture payloads on transfer
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			end_s1  <= stream_end;
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign event_res = res_s2.event_res;
	assign str_byte  = res_s2.str_byte;
	assign str_last  = res_s2.str_last;
	assign int_value = res_s2.int_value;
	assign err_code  = res_s2.err_code;

	// Error code present exactly on error events
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((res_s2.event_res == EV_ERROR) == (res_s2.err_code != ER_NONE)))
		else $error("error code does not match event");

	// Last mark only on string bytes
	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.str_last) |-> (res_s2.event_res == EV_BYTE))
		else $error("last mark on a non-byte event");

	// A waiting input byte is consumed when the result register frees
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> valid_s2)
		else $error("decoded byte lost between stages");

endmodule

>>> bench/bencode_token_decoder_tb.sv
module bencode_token_decoder_tb
	import btd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STREAM_BYTES = 1100;
	localparam int IDLE_LIMIT   = 3000;

	// Decoder phases of the local token tracker
	typedef enum logic [2:0] {
		TOK_IDLE,
		TOK_INT_START,
		TOK_INT_SIGN,
		TOK_INT_DIGITS,
		TOK_LEN,
		TOK_STR
	} tok_phase_t;

	// One entry of the outgoing byte stream; a pause entry holds the sender until drained
	typedef struct {
		logic [7:0] data;
		logic       stop;
		bit         pause;
	} stream_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'd0;
	logic        stream_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_res;
	logic [7:0]  str_byte;
	logic        str_last;
	logic [63:0] int_value;
	logic [2:0]  err_code;

	stream_item_t tx_items[$];
	btd_result_t  due_results[$];

	// Token tracker state
	tok_phase_t  tok_phase = TOK_IDLE;
	logic [63:0] tok_mag = '0;
	logic        tok_neg = 1'b0;
	logic        tok_digits = 1'b0;
	logic        tok_lead_zero = 1'b0;
	logic [63:0] tok_left = '0;

	int queued_bytes = 0;
	int sent_bytes = 0;
	int recv_count = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int next_hold = 300;
	int mode_left = 0;
	int stall_mode = 0;
	int pattern_step = 0;
	int ev_tally[8];
	int er_tally[8];

	bencode_token_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_res  (event_res),
		.str_byte   (str_byte),
		.str_last   (str_last),
		.int_value  (int_value),
		.err_code   (err_code)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Drop any partial token and return to idle
	function automatic void clear_token();
		tok_phase     = TOK_IDLE;
		tok_mag       = '0;
		tok_neg       = 1'b0;
		tok_digits    = 1'b0;
		tok_lead_zero = 1'b0;
		tok_left      = '0;
	endfunction

	function automatic btd_result_t token_error(input logic [2:0] code);
		btd_result_t r;
		clear_token();
		r           = '0;
		r.event_res = EV_ERROR;
		r.err_code  = code;
		return r;
	endfunction

	// Advance the token tracker by one stream byte and return the result it yields
	function automatic btd_result_t decode_byte(input logic [7:0] c, input logic stop);
		btd_result_t r;
		logic [63:0] d;
		logic [63:0] lim;
		logic        is_dig;
		r      = '0;
		d      = 64'(c) - 64'(CH_ZERO);
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		if (stop) begin
			if (tok_phase != TOK_IDLE)
				r = token_error(ER_TRUNC);
			return r;
		end
		case (tok_phase)
			TOK_IDLE: begin
				clear_token();
				if (c == CH_I) begin
					tok_phase = TOK_INT_START;
				end else if (is_dig) begin
					tok_left  = d;
					tok_phase = TOK_LEN;
				end else begin
					r = token_error(ER_FIRST);
				end
			end
			TOK_INT_START, TOK_INT_SIGN, TOK_INT_DIGITS: begin
				if (tok_phase == TOK_INT_START && (c == CH_MINUS || c == CH_PLUS)) begin
					tok_neg   = (c == CH_MINUS);
					tok_phase = TOK_INT_SIGN;
				end else if (is_dig) begin
					lim = tok_neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
					if (tok_lead_zero) begin
						r = token_error(ER_INT);
					end else if (tok_mag > (lim - d) / 64'd10) begin
						r = token_error(ER_OVF);
					end else begin
						if (!tok_digits && d == 64'd0)
							tok_lead_zero = 1'b1;
						tok_mag    = tok_mag * 64'd10 + d;
						tok_digits = 1'b1;
						tok_phase  = TOK_INT_DIGITS;
					end
				end else if (c == CH_E && tok_digits) begin
					r.event_res = EV_INT;
					r.int_value = tok_neg ? (64'd0 - tok_mag) : tok_mag;
					clear_token();
				end else begin
					r = token_error(ER_INT);
				end
			end
			TOK_LEN: begin
				lim = {64{1'b1}} >> (64 - BTD_LENGTH_WIDTH);
				if (is_dig) begin
					if (tok_left > (lim - d) / 64'd10)
						r = token_error(ER_LEN);
					else
						tok_left = tok_left * 64'd10 + d;
				end else if (c == CH_COLON) begin
					if (tok_left == 64'd0) begin
						clear_token();
						r.event_res = EV_EMPTY;
					end else begin
						tok_phase = TOK_STR;
					end
				end else begin
					r = token_error(ER_LEN);
				end
			end
			TOK_STR: begin
				r.event_res = EV_BYTE;
				r.str_byte  = c;
				if (tok_left <= 64'd1) begin
					r.str_last = 1'b1;
					clear_token();
				end else begin
					tok_left = tok_left - 64'd1;
				end
			end
			default: clear_token();
		endcase
		return r;
	endfunction

	// Stream building
	task automatic push_byte(input logic [7:0] b);
		tx_items.push_back('{data: b, stop: 1'b0, pause: 1'b0});
		queued_bytes++;
	endtask

	task automatic push_end();
		tx_items.push_back('{data: 8'($urandom_range(0, 255)), stop: 1'b1, pause: 1'b0});
		queued_bytes++;
	endtask

	task automatic push_pause();
		tx_items.push_back('{data: 8'd0, stop: 1'b0, pause: 1'b1});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_int_token();
		logic [63:0] mag;
		push_byte(CH_I);
		case ($urandom_range(0, 3))
			0: push_byte(CH_MINUS);
			1: push_byte(CH_PLUS);
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0: push_byte(CH_ZERO);
			1: push_text("9223372036854775807");
			2: push_text("9223372036854775808");
			3: push_text("18446744073709551615");
			default: begin
				mag = {$urandom, $urandom} >> $urandom_range(0, 63);
				push_text($sformatf("%0d", mag));
			end
		endcase
		push_byte(CH_E);
	endtask

	task automatic push_str_token();
		int unsigned len;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) push_byte(CH_ZERO);
		push_text($sformatf("%0d", len));
		push_byte(CH_COLON);
		repeat (len) push_byte(8'($urandom_range(0, 255)));
	endtask

	// Reset, stream contents and end of run
	initial begin
		int pick;
		int n;
		int next_pause;
		next_pause = 350;
		for (int i = 0; i < 8; i++) begin
			ev_tally[i] = 0;
			er_tally[i] = 0;
		end

		// Directed opening: zero, negative zero, empty string, payload extremes,
		// bad first bytes, malformed integers, bad length and truncation
		push_text("i0e");
		push_text("i-0e");
		push_text("0:");
		push_text("2:");
		push_byte(8'h00);
		push_byte(8'hff);
		push_byte(8'h00);
		push_byte(8'hff);
		push_text("ie");
		push_text("i01");
		push_text("i+-");
		push_text("1;");
		push_byte(CH_I);
		push_end();
		push_end();
		push_pause();

		// Random stream: mostly well-formed tokens, some broken ones and noise
		while (queued_bytes < STREAM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				push_int_token();
			end else if (pick < 70) begin
				push_str_token();
			end else if (pick < 76) begin
				case ($urandom_range(0, 2))
					0: begin
						push_text("4294967295");
						push_end();
					end
					1: push_text("4294967296");
					default: begin
						push_text("00000000004294967295");
						push_byte(CH_NINE);
					end
				endcase
			end else if (pick < 90) begin
				case ($urandom_range(0, 5))
					0: begin
						push_byte(CH_I);
						if ($urandom_range(0, 1) == 1)
							push_byte(CH_MINUS);
						repeat ($urandom_range(0, 5)) push_byte(8'(CH_ZERO + $urandom_range(0, 9)));
						push_end();
					end
					1: begin
						n = $urandom_range(1, 20);
						push_text($sformatf("%0d", n));
						if ($urandom_range(0, 1) == 1) begin
							push_byte(CH_COLON);
							repeat ($urandom_range(0, n - 1)) push_byte(8'($urandom_range(0, 255)));
						end
						push_end();
					end
					2: begin
						push_byte(CH_I);
						push_byte(8'($urandom_range(0, 255)));
						push_byte(CH_E);
					end
					3: begin
						push_text("i0");
						push_byte(8'(CH_ZERO + $urandom_range(0, 9)));
					end
					4: begin
						push_byte(CH_I);
						push_byte(($urandom_range(0, 1) == 1) ? CH_MINUS : CH_PLUS);
						push_byte(($urandom_range(0, 1) == 1) ? CH_E : CH_MINUS);
					end
					default: begin
						push_text($sformatf("%0d", $urandom_range(1, 99)));
						push_byte(8'($urandom_range(0, 255)));
					end
				endcase
			end else begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 3) == 0)
						push_end();
					else
						push_byte(8'($urandom_range(0, 255)));
				end
			end
			if (queued_bytes >= next_pause) begin
				push_pause();
				next_pause += 350;
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (tx_items.size() != 0 || in_valid) @(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes; results %0d: int %0d, str byte %0d, empty %0d, error %0d",
			sent_bytes, recv_count, ev_tally[EV_INT], ev_tally[EV_BYTE], ev_tally[EV_EMPTY],
			ev_tally[EV_ERROR]);
		$display("Error kinds: first %0d, integer %0d, overflow %0d, length %0d, truncated %0d",
			er_tally[ER_FIRST], er_tally[ER_INT], er_tally[ER_OVF], er_tally[ER_LEN],
			er_tally[ER_TRUNC]);
		if (mismatches == 0 && due_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Sender: offer stream bytes in bursts, hold on pause entries until drained
	always @(posedge clk or negedge arst_n) begin : drive
		stream_item_t it;
		logic         nv;
		logic [7:0]   nb;
		logic         ne;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_byte    <= 8'd0;
			stream_end <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			nv = in_valid;
			nb = in_byte;
			ne = stream_end;
			if (in_valid && in_ready) begin
				due_results.push_back(decode_byte(in_byte, stream_end));
				sent_bytes++;
			end
			if (!in_valid || in_ready) begin
				nv = 1'b0;
				if (tx_items.size() != 0 && tx_items[0].pause && due_results.size() == 0)
					void'(tx_items.pop_front());
				if (gap_left > 0) begin
					gap_left--;
				end else if (tx_items.size() != 0 && !tx_items[0].pause) begin
					it = tx_items.pop_front();
					nv = 1'b1;
					nb = it.data;
					ne = it.stop;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			in_valid   <= nv;
			in_byte    <= nb;
			stream_end <= ne;
		end
	end

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch on result %0d, %s: expected %0h, got %0h",
					recv_count, name, want, got);
		end
	endtask

	// Receiver: check each transfer against the oldest prediction, stall on its own pattern
	always @(posedge clk or negedge arst_n) begin : observe
		btd_result_t want;
		logic        rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result %0d: event %0d", recv_count, event_res);
				end else begin
					want = due_results.pop_front();
					check_field("event_res", 64'(want.event_res), 64'(event_res));
					check_field("str_byte", 64'(want.str_byte), 64'(str_byte));
					check_field("str_last", 64'(want.str_last), 64'(str_last));
					check_field("int_value", want.int_value, int_value);
					check_field("err_code", 64'(want.err_code), 64'(err_code));
					ev_tally[want.event_res]++;
					er_tally[want.err_code]++;
				end
				recv_count++;
			end

			pattern_step++;
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end

			// Long hold-off now and then so the input side backs up
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (recv_count >= next_hold) begin
				hold_left = $urandom_range(150, 300);
				next_hold += 500;
				rdy = 1'b0;
			end else begin
				case (stall_mode)
					0: rdy = 1'b1;
					1: rdy = ($urandom_range(0, 3) != 0);
					2: rdy = ($urandom_range(0, 3) == 0);
					default: rdy = ((pattern_step % 5) != 0);
				endcase
			end
			out_ready <= rdy;
		end
	end

	// Watchdog: end the run if no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
